[rtl/obd_pkg.sv]
// ----------------------------------------------------------------------------
// obd_pkg
// shared types, codes and character helpers of the obd response hex parser
// ----------------------------------------------------------------------------
`default_nettype none

package obd_pkg;

   localparam int RESP_CHAR_W  = 8;
   localparam int DATA_BYTE_W  = 8;
   localparam int BYTE_INDEX_W = 5;
   localparam int STATUS_W     = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [7:0] PREAMBLE_BASE = 8'h40;
   localparam logic [7:0] MODE_RESET    = 8'h01;

   localparam logic [2:0] ND_LEN = 3'd7;
   localparam logic [4:0] NC_LEN = 5'd17;

   localparam logic [CSR_ADDR_W-1:0] CSR_SERVICE_MODE = 3'd0;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_DATA    = 3'd1,
      ST_NO_CONNECT = 3'd2,
      ST_NO_PRE     = 3'd3,
      ST_ODD        = 3'd4,
      ST_OVERFLOW   = 3'd5
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic                    kind;
      logic [DATA_BYTE_W-1:0]  data_byte;
      logic [BYTE_INDEX_W-1:0] byte_index;
      logic [STATUS_W-1:0]     status;
      logic                    last;
   } rsp_item_type;

   // "NO DATA"
   function automatic logic [7:0] nd_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = "N";
         3'd1: c = "O";
         3'd2: c = " ";
         3'd3: c = "D";
         3'd4: c = "A";
         3'd5: c = "T";
         3'd6: c = "A";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "UNABLE TO CONNECT"
   function automatic logic [7:0] nc_char(input logic [4:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:  c = "U";
         5'd1:  c = "N";
         5'd2:  c = "A";
         5'd3:  c = "B";
         5'd4:  c = "L";
         5'd5:  c = "E";
         5'd6:  c = " ";
         5'd7:  c = "T";
         5'd8:  c = "O";
         5'd9:  c = " ";
         5'd10: c = "C";
         5'd11: c = "O";
         5'd12: c = "N";
         5'd13: c = "N";
         5'd14: c = "E";
         5'd15: c = "C";
         5'd16: c = "T";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h37 + {4'h0, nib};
      end
      return c;
   endfunction

   // returns {is_hex, nibble}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      logic       ok;
      v  = 8'h00;
      ok = 1'b0;
      if (c >= "0" && c <= "9") begin
         v  = c - 8'h30;
         ok = 1'b1;
      end else if (c >= "A" && c <= "F") begin
         v  = c - 8'h37;
         ok = 1'b1;
      end else if (c >= "a" && c <= "f") begin
         v  = c - 8'h57;
         ok = 1'b1;
      end
      return {ok, v[3:0]};
   endfunction

endpackage

`default_nettype wire

[rtl/obd_req_if.sv]
// ----------------------------------------------------------------------------
// obd_req_if
// input word channel: one response character with its end marker
// ----------------------------------------------------------------------------
`default_nettype none

interface obd_req_if
   import obd_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [RESP_CHAR_W-1:0] resp_char;
   logic                   end_of_response;

   modport source (output valid, output resp_char, output end_of_response, input ready);
   modport sink   (input valid, input resp_char, input end_of_response, output ready);
endinterface

`default_nettype wire

[rtl/obd_rsp_if.sv]
// ----------------------------------------------------------------------------
// obd_rsp_if
// result word channel: data byte or final status
// ----------------------------------------------------------------------------
`default_nettype none

interface obd_rsp_if
   import obd_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [DATA_BYTE_W-1:0]  data_byte;
   logic [BYTE_INDEX_W-1:0] byte_index;
   logic [STATUS_W-1:0]     status;
   logic                    last;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output status, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_index,
                   input status, input last, output ready);
endinterface

`default_nettype wire

[rtl/obd_response_hex_parser.sv]
// ----------------------------------------------------------------------------
// obd_response_hex_parser
// a result word is written into the result queue when its character is taken
// one character per cycle while two queue entries are free; a character that
//   ends the response after completing a byte yields two words, which drain
//   one per cycle; the four-entry result queue sets the pace when rsp backs up
// reset: synchronous, clears parser state and queue, service_mode back to 1
// ----------------------------------------------------------------------------
`default_nettype none

module obd_response_hex_parser
   import obd_pkg::*;
#(
   parameter int MAX_BYTES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   obd_req_if.sink                    req_ch,
   obd_rsp_if.source                  rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int CW = $clog2(MAX_BYTES + 1);

   // configuration
   logic [7:0] service_mode_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == CSR_SERVICE_MODE);
   assign prdata = (paddr == CSR_SERVICE_MODE) ?
                   {{(CSR_DATA_W-8){1'b0}}, service_mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         service_mode_ff <= MODE_RESET;
      end else if (csr_wr) begin
         service_mode_ff <= pwdata[7:0];
      end
   end

   // parser state
   logic [2:0]    nd_prog_ff, nd_prog_in;
   logic [4:0]    nc_prog_ff, nc_prog_in;
   logic          saw_nd_ff, saw_nd_in;
   logic          saw_nc_ff, saw_nc_in;
   logic          prev_first_ff, prev_first_in;
   logic          in_data_ff, in_data_in;
   logic [3:0]    high_nib_ff, high_nib_in;
   logic          have_high_ff, have_high_in;
   logic [CW-1:0] byte_cnt_ff, byte_cnt_in;
   logic          ovf_ff, ovf_in;

   // result queue
   rsp_item_type q_mem [4];
   logic [1:0]   q_wr_ff, q_rd_ff;
   logic [2:0]   q_cnt_ff, q_cnt_in;

   logic         accept, pop;
   logic [7:0]   c;
   logic [7:0]   pre, p1, p2;
   logic [4:0]   hv;
   logic [7:0]   pkt;
   logic         emit_data;
   logic [7:0]   emit_byte;
   logic [CW+4:0] idx_ext;
   logic [2:0]   st;
   rsp_item_type data_item, stat_item, item0, item1;
   logic [1:0]   n_push;

   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign c      = req_ch.resp_char;

   assign req_ch.ready = (q_cnt_ff <= 3'd2);

   always_comb begin
      pre = PREAMBLE_BASE + service_mode_ff;
      p1  = hex_char(pre[7:4]);
      p2  = hex_char(pre[3:0]);
      hv  = hex_value(c);

      nd_prog_in    = nd_prog_ff;
      nc_prog_in    = nc_prog_ff;
      saw_nd_in     = saw_nd_ff;
      saw_nc_in     = saw_nc_ff;
      prev_first_in = prev_first_ff;
      in_data_in    = in_data_ff;
      high_nib_in   = high_nib_ff;
      have_high_in  = have_high_ff;
      byte_cnt_in   = byte_cnt_ff;
      ovf_in        = ovf_ff;
      emit_data     = 1'b0;
      emit_byte     = pre;
      idx_ext       = '0;
      pkt           = {high_nib_ff, hv[3:0]};

      // text matchers
      if (nd_prog_ff < ND_LEN && c == nd_char(nd_prog_ff)) begin
         if (nd_prog_ff + 3'd1 == ND_LEN) begin
            nd_prog_in = 3'd0;
            saw_nd_in  = 1'b1;
         end else begin
            nd_prog_in = nd_prog_ff + 3'd1;
         end
      end else begin
         nd_prog_in = (c == nd_char(3'd0)) ? 3'd1 : 3'd0;
      end

      if (nc_prog_ff < NC_LEN && c == nc_char(nc_prog_ff)) begin
         if (nc_prog_ff + 5'd1 == NC_LEN) begin
            nc_prog_in = 5'd0;
            saw_nc_in  = 1'b1;
         end else begin
            nc_prog_in = nc_prog_ff + 5'd1;
         end
      end else begin
         nc_prog_in = (c == nc_char(5'd0)) ? 5'd1 : 5'd0;
      end

      // preamble search and nibble packing
      if (!in_data_ff) begin
         if (prev_first_ff && c == p2) begin
            in_data_in   = 1'b1;
            have_high_in = 1'b0;
            byte_cnt_in  = CW'(1);
            emit_data    = 1'b1;
            emit_byte    = pre;
            idx_ext      = '0;
         end
         prev_first_in = (c == p1);
      end else if (hv[4]) begin
         if (!have_high_ff) begin
            high_nib_in  = hv[3:0];
            have_high_in = 1'b1;
         end else begin
            have_high_in = 1'b0;
            if (byte_cnt_ff < CW'(MAX_BYTES)) begin
               emit_data   = 1'b1;
               emit_byte   = pkt;
               idx_ext     = {5'd0, byte_cnt_ff};
               byte_cnt_in = byte_cnt_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end

      if (saw_nd_in) begin
         st = ST_NO_DATA;
      end else if (saw_nc_in) begin
         st = ST_NO_CONNECT;
      end else if (!in_data_in) begin
         st = ST_NO_PRE;
      end else if (have_high_in) begin
         st = ST_ODD;
      end else if (ovf_in) begin
         st = ST_OVERFLOW;
      end else begin
         st = ST_OK;
      end

      // end of response clears per-response state
      if (req_ch.end_of_response) begin
         nd_prog_in    = '0;
         nc_prog_in    = '0;
         saw_nd_in     = 1'b0;
         saw_nc_in     = 1'b0;
         prev_first_in = 1'b0;
         in_data_in    = 1'b0;
         high_nib_in   = '0;
         have_high_in  = 1'b0;
         byte_cnt_in   = '0;
         ovf_in        = 1'b0;
      end

      data_item.kind       = KIND_DATA;
      data_item.data_byte  = emit_byte;
      data_item.byte_index = idx_ext[4:0];
      data_item.status     = ST_OK;
      data_item.last       = 1'b0;

      stat_item.kind       = KIND_STATUS;
      stat_item.data_byte  = '0;
      stat_item.byte_index = '0;
      stat_item.status     = st;
      stat_item.last       = 1'b1;

      item0  = emit_data ? data_item : stat_item;
      item1  = stat_item;
      n_push = 2'({1'b0, emit_data} + {1'b0, req_ch.end_of_response});
      if (!accept) begin
         n_push = 2'd0;
      end

      q_cnt_in = q_cnt_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_prog_ff    <= '0;
         nc_prog_ff    <= '0;
         saw_nd_ff     <= 1'b0;
         saw_nc_ff     <= 1'b0;
         prev_first_ff <= 1'b0;
         in_data_ff    <= 1'b0;
         high_nib_ff   <= '0;
         have_high_ff  <= 1'b0;
         byte_cnt_ff   <= '0;
         ovf_ff        <= 1'b0;
      end else if (accept) begin
         nd_prog_ff    <= nd_prog_in;
         nc_prog_ff    <= nc_prog_in;
         saw_nd_ff     <= saw_nd_in;
         saw_nc_ff     <= saw_nc_in;
         prev_first_ff <= prev_first_in;
         in_data_ff    <= in_data_in;
         high_nib_ff   <= high_nib_in;
         have_high_ff  <= have_high_in;
         byte_cnt_ff   <= byte_cnt_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_ff + n_push;
         q_rd_ff  <= q_rd_ff + {1'b0, pop};
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_mem[q_wr_ff] <= item0;
      end
      if (n_push == 2'd2) begin
         q_mem[q_wr_ff + 2'd1] <= item1;
      end
   end

   assign rsp_ch.valid      = (q_cnt_ff != 3'd0);
   assign rsp_ch.kind       = q_mem[q_rd_ff].kind;
   assign rsp_ch.data_byte  = q_mem[q_rd_ff].data_byte;
   assign rsp_ch.byte_index = q_mem[q_rd_ff].byte_index;
   assign rsp_ch.status     = q_mem[q_rd_ff].status;
   assign rsp_ch.last       = q_mem[q_rd_ff].last;

endmodule

`default_nettype wire

[verif/tb_obd_response_hex_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_obd_response_hex_parser
// drives adapter replies one character per word and checks every result word
// against a cycle-free software parser kept in a scoreboard: the preamble
// byte and the data bytes after it, their indexes, and the final status of each reply, across
// several service modes and sender/receiver idle profiles
// ----------------------------------------------------------------------------

module tb_obd_response_hex_parser;
   import obd_pkg::*;

   localparam int REPLY_CAPACITY = 32;
   localparam logic [7:0] CR = 8'h0D;
   localparam logic [7:0] LF = 8'h0A;

   class response_scoreboard;
      logic [7:0]   mode;
      int           nd_prog;
      int           nc_prog;
      bit           saw_nd;
      bit           saw_nc;
      bit           prev_hi;
      bit           in_body;
      bit           have_nib;
      logic [3:0]   nib;
      int           kept;
      bit           dropped;
      string        nd_text = "NO DATA";
      string        nc_text = "UNABLE TO CONNECT";
      rsp_item_type expected_words[$];
      int unsigned  mismatches;
      int unsigned  words_checked;
      int unsigned  status_count[8];

      function new();
         mode = MODE_RESET;
         clear_reply();
      endfunction

      function void clear_reply();
         nd_prog  = 0;
         nc_prog  = 0;
         saw_nd   = 0;
         saw_nc   = 0;
         prev_hi  = 0;
         in_body  = 0;
         have_nib = 0;
         nib      = 4'h0;
         kept     = 0;
         dropped  = 0;
      endfunction

      function logic [7:0] digit_char(input logic [3:0] n);
         return (n > 4'd9) ? (8'h41 + n - 8'd10) : (8'h30 + n);
      endfunction

      function int digit_value(input logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
         if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
         if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
         return -1;
      endfunction

      // neither text repeats its first letter, so a miss restarts at letter one
      function int advance(input int prog, input logic [7:0] c, input string txt,
                           inout bit hit);
         if (prog < txt.len() && c == txt[prog]) begin
            prog++;
            if (prog == txt.len()) begin
               hit  = 1;
               prog = 0;
            end
            return prog;
         end
         return (c == txt[0]) ? 1 : 0;
      endfunction

      function void push_word(input kind_type k, input logic [7:0] b, input int idx,
                              input status_type st);
         rsp_item_type w;
         w.kind       = k;
         w.data_byte  = b;
         w.byte_index = idx[BYTE_INDEX_W-1:0];
         w.status     = st;
         w.last       = (k == KIND_STATUS);
         expected_words.push_back(w);
      endfunction

      function void take_char(input logic [7:0] c, input bit eor);
         logic [7:0] pre;
         logic [7:0] hi;
         logic [7:0] lo;
         int         v;
         status_type st;
         pre = PREAMBLE_BASE + mode;
         hi  = digit_char(pre[7:4]);
         lo  = digit_char(pre[3:0]);
         nd_prog = advance(nd_prog, c, nd_text, saw_nd);
         nc_prog = advance(nc_prog, c, nc_text, saw_nc);
         if (!in_body) begin
            if (prev_hi && c == lo) begin
               in_body  = 1;
               have_nib = 0;
               kept     = 1;
               push_word(KIND_DATA, pre, 0, ST_OK);
            end
            prev_hi = (c == hi);
         end else begin
            v = digit_value(c);
            if (v >= 0) begin
               if (!have_nib) begin
                  nib      = v[3:0];
                  have_nib = 1;
               end else begin
                  have_nib = 0;
                  if (kept < REPLY_CAPACITY) begin
                     push_word(KIND_DATA, {nib, v[3:0]}, kept, ST_OK);
                     kept++;
                  end else begin
                     dropped = 1;
                  end
               end
            end
         end
         if (eor) begin
            if (saw_nd) st = ST_NO_DATA;
            else if (saw_nc) st = ST_NO_CONNECT;
            else if (!in_body) st = ST_NO_PRE;
            else if (have_nib) st = ST_ODD;
            else if (dropped) st = ST_OVERFLOW;
            else st = ST_OK;
            push_word(KIND_STATUS, 8'h00, 0, st);
            status_count[int'(st)]++;
            clear_reply();
         end
      endfunction

      function void report(input string what, input rsp_item_type exp,
                           input rsp_item_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s: expected kind %0d byte %02h idx %0d status %0d last %0d,",
                     $time, what, exp.kind, exp.data_byte, exp.byte_index, exp.status,
                     exp.last);
            $display("   got kind %0d byte %02h idx %0d status %0d last %0d",
                     got.kind, got.data_byte, got.byte_index, got.status, got.last);
         end
      endfunction

      function void check_word(input rsp_item_type got);
         rsp_item_type exp;
         if (expected_words.size() == 0) begin
            report("unexpected word", '0, got);
            return;
         end
         exp = expected_words.pop_front();
         words_checked++;
         if (got.kind !== exp.kind || got.data_byte !== exp.data_byte ||
             got.byte_index !== exp.byte_index || got.status !== exp.status ||
             got.last !== exp.last)
            report("word mismatch", exp, got);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   obd_req_if req_if ();
   obd_rsp_if rsp_if ();

   obd_response_hex_parser #(
      .MAX_BYTES (REPLY_CAPACITY)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   response_scoreboard sb = new();

   int          send_gap;
   int          recv_gap;
   int          hold_requests;
   int unsigned chars_sent;
   int unsigned replies_sent;
   int unsigned csr_errors;
   logic [7:0]  reply_chars[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: checks accepted words, idles at random, takes long holds on request
   initial begin : receiver
      int hold_left;
      int holds_done;
      hold_left  = 0;
      holds_done = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_word('{rsp_if.kind, rsp_if.data_byte, rsp_if.byte_index,
                            rsp_if.status, rsp_if.last});
         if (hold_left == 0 && holds_done < hold_requests) begin
            hold_left = 400;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_gap);
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input bit eor);
      while ($urandom_range(99) < send_gap) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.resp_char       <= c;
      req_if.end_of_response <= eor;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.take_char(c, eor);
      chars_sent++;
   endtask

   task automatic send_reply();
      int i;
      for (i = 0; i < reply_chars.size(); i++)
         send_char(reply_chars[i], i == reply_chars.size() - 1);
      replies_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] a,
                             input logic [CSR_DATA_W-1:0] wd,
                             output logic [CSR_DATA_W-1:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= a;
      pwdata  <= wd;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_mode(input logic [7:0] want);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, CSR_SERVICE_MODE, '0, rd);
      if (rd[7:0] !== want) begin
         csr_errors++;
         $display("%0t: service_mode reads %02h, expected %02h", $time, rd[7:0], want);
      end
   endtask

   task automatic set_mode(input logic [7:0] m);
      logic [CSR_DATA_W-1:0] rd;
      drain();
      csr_access(1'b1, CSR_SERVICE_MODE, {24'h0, m}, rd);
      sb.mode = m;
      check_mode(m);
   endtask

   function automatic void add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) reply_chars.push_back(s[i]);
   endfunction

   function automatic void add_noise(input int n);
      int i;
      for (i = 0; i < n; i++) reply_chars.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void add_hex(input logic [7:0] b, input bit lower);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = sb.digit_char(b[7:4]);
      lo = sb.digit_char(b[3:0]);
      if (lower && hi > 8'h39) hi = hi + 8'h20;
      if (lower && lo > 8'h39) lo = lo + 8'h20;
      reply_chars.push_back(hi);
      reply_chars.push_back(lo);
   endfunction

   function automatic void make_reply(input bit long_reply);
      int         pick;
      int         n;
      int         i;
      logic [7:0] pre;
      logic [7:0] seps[5];
      string      txt;
      seps = '{8'h20, CR, LF, 8'h3E, 8'h3A};
      reply_chars.delete();
      pre  = PREAMBLE_BASE + sb.mode;
      pick = long_reply ? 0 : $urandom_range(99);
      if (pick < 62) begin
         // reply with preamble and hex bytes, random spacing and case; at times noise, an odd digit or overflow
         if ($urandom_range(3) == 0) add_noise($urandom_range(1, 5));
         add_hex(pre, 1'b0);
         if (long_reply) n = 30;
         else if ($urandom_range(9) == 0) n = $urandom_range(28, 40);
         else n = $urandom_range(0, 7);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(2) != 0) reply_chars.push_back(seps[$urandom_range(4)]);
            add_hex(8'($urandom_range(255)), $urandom_range(3) == 0);
         end
         if ($urandom_range(7) == 0)
            reply_chars.push_back(sb.digit_char(4'($urandom_range(15))));
         if ($urandom_range(2) == 0) reply_chars.push_back(CR);
      end else if (pick < 72) begin
         if ($urandom_range(1)) begin
            add_hex(pre, 1'b0);
            add_hex(8'($urandom_range(255)), 1'b0);
         end
         add_text("NO DATA");
         if ($urandom_range(1)) reply_chars.push_back(CR);
      end else if (pick < 80) begin
         if ($urandom_range(1)) add_text("SEARCHING...");
         add_text("UNABLE TO CONNECT");
         if ($urandom_range(1)) add_hex(pre, 1'b0);
      end else if (pick < 88) begin
         // error text cut short, sometimes followed by a real reply
         txt = $urandom_range(1) ? "NO DATA" : "UNABLE TO CONNECT";
         add_text(txt.substr(0, $urandom_range(0, txt.len() - 2)));
         if ($urandom_range(1)) add_noise(1);
         if ($urandom_range(1)) begin
            add_hex(pre, 1'b0);
            add_hex(8'($urandom_range(255)), 1'b1);
         end
      end else if (pick < 94) begin
         // preamble digits split by a blank or by a lower-case copy of the preamble
         reply_chars.push_back(sb.digit_char(pre[7:4]));
         if ($urandom_range(1)) reply_chars.push_back(8'h20);
         else add_hex(pre, 1'b1);
         reply_chars.push_back(sb.digit_char(pre[3:0]));
         add_hex(8'($urandom_range(255)), 1'b0);
      end else begin
         add_noise($urandom_range(1, 12));
      end
   endfunction

   task automatic run_replies(input int unsigned count);
      int unsigned start;
      start = chars_sent;
      while (chars_sent - start < count) begin
         make_reply(1'b0);
         send_reply();
      end
   endtask

   initial begin : stimulus
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.resp_char       <= 8'h00;
      req_if.end_of_response <= 1'b0;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= '0;
      pwdata                 <= '0;
      send_gap      = 7;
      recv_gap      = 60;
      hold_requests = 0;
      chars_sent    = 0;
      replies_sent  = 0;
      csr_errors    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_mode(MODE_RESET);

      // lower-case digits, a NUL inside the body, an unpaired last digit
      reply_chars = '{"4", "1", " ", "0", "c", 8'h00, "F"};
      send_reply();
      // preamble on the closing character
      reply_chars = '{"4", "1"};
      send_reply();
      // data ahead of an error text
      reply_chars.delete();
      add_text("41NO DATA");
      send_reply();
      // single top-code character, no preamble
      reply_chars = '{8'hFF};
      send_reply();
      // leading NUL, byte completed by the closing character
      reply_chars = '{8'h00, "4", "1", "a", "B"};
      send_reply();

      set_mode(8'd0);
      run_replies(330);
      set_mode(8'd191);
      run_replies(300);

      send_gap = 60;
      recv_gap = 7;
      set_mode(8'hFF);
      run_replies(250);
      set_mode(8'($urandom_range(191)));
      run_replies(300);

      send_gap = 0;
      recv_gap = 0;
      set_mode(8'd1);
      hold_requests = 1;
      make_reply(1'b1);
      send_reply();
      run_replies(300);
      set_mode(8'($urandom_range(191)));
      run_replies(300);

      drain();
      repeat (10) @(posedge clock);
      $display("sent %0d characters in %0d replies; %0d result words checked",
               chars_sent, replies_sent, sb.words_checked);
      $display("status words: ok %0d, no data %0d, no connect %0d, no preamble %0d, odd %0d, overflow %0d",
               sb.status_count[ST_OK], sb.status_count[ST_NO_DATA],
               sb.status_count[ST_NO_CONNECT], sb.status_count[ST_NO_PRE],
               sb.status_count[ST_ODD], sb.status_count[ST_OVERFLOW]);
      if (sb.mismatches == 0 && csr_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
